// ===== rtl/rilbp_pkg.sv =====
package rilbp_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MIN_SIDE       = 3;
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CODE_W         = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic interior;
        logic row_end;
        logic frame_end;
    } t_meta;

    // smallest of the eight circular rotations of a byte
    function automatic logic [CODE_W-1:0] min_rotation(input logic [CODE_W-1:0] b);
        logic [CODE_W-1:0] best;
        logic [CODE_W-1:0] rot;
        best = b;
        for (int i = 1; i < CODE_W; i++) begin
            rot = (b << i) | (b >> (CODE_W - i));
            if (rot < best) begin
                best = rot;
            end
        end
        return best;
    endfunction

endpackage

// ===== rtl/rotation_invariant_lbp_3x3.sv =====
// Rotation-invariant 3x3 LBP over a raster pixel stream. One pixel is taken
// per clock while the output is not stalled; each interior pixel yields one
// pattern code (minimum over the eight rotations of its neighbour comparison
// byte), registered through the line-store stage, the window stage and the
// output register; border pixels yield nothing. Two block-RAM line stores of
// MAX_WIDTH entries, each with one read and one write port, supply the two
// rows above. Input stall rises only when the line-store stage, the window
// stage (holding an interior pixel) and the output register are all full and
// the output is stalled. Writing either size register restarts the frame at
// the next pixel; sizes are clamped to 3..MAX_WIDTH and 3..1024.
module rotation_invariant_lbp_3x3 #(
    parameter int MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [PIXEL_BITS-1:0]             i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rilbp_pkg::CODE_W-1:0]      o_pattern_code,
    output logic                              o_row_end,
    output logic                              o_frame_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rilbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rilbp_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                  in_fire;
    logic [CW-1:0]         col;
    rilbp_pkg::t_meta      pos_meta, s1_meta;
    logic                  s1_valid, s1_take;
    logic [PIXEL_BITS-1:0] s1_upper, s1_middle, s1_pixel;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && !o_in_stall;

    rilbp_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (in_fire),
        .o_col       (col),
        .o_meta      (pos_meta)
    );

    rilbp_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_linebuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_col    (col),
        .i_pixel  (i_pixel),
        .i_meta   (pos_meta),
        .o_valid  (s1_valid),
        .i_take   (s1_take),
        .o_upper  (s1_upper),
        .o_middle (s1_middle),
        .o_pixel  (s1_pixel),
        .o_meta   (s1_meta)
    );

    rilbp_core #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .o_take      (s1_take),
        .i_upper     (s1_upper),
        .i_middle    (s1_middle),
        .i_pixel     (s1_pixel),
        .i_meta      (s1_meta),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_code      (o_pattern_code),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== rtl/rilbp_pos.sv =====
module rilbp_pos #(
    parameter int MAX_WIDTH = rilbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rilbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rilbp_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                 i_adv,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_col,
    output rilbp_pkg::t_meta                     o_meta
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int MW_B  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = ((MW_B > rilbp_pkg::CFG_W) ? MW_B : rilbp_pkg::CFG_W) + 1;
    localparam int RW    = rilbp_pkg::ROW_W;

    logic [rilbp_pkg::CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]               r_col, n_col;
    logic [RW-1:0]               r_row, n_row;
    logic [CMP_W-1:0]            w_eff, h_eff, col_nx, row_nx, w_raw, h_raw;
    logic                        row_wrap, frame_wrap;

    assign w_raw = CMP_W'(r_width);
    assign h_raw = CMP_W'(r_height);

    always_comb begin
        if (w_raw < CMP_W'(rilbp_pkg::MIN_SIDE)) begin
            w_eff = CMP_W'(rilbp_pkg::MIN_SIDE);
        end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < CMP_W'(rilbp_pkg::MIN_SIDE)) begin
            h_eff = CMP_W'(rilbp_pkg::MIN_SIDE);
        end else if (h_raw > CMP_W'(rilbp_pkg::MAX_HEIGHT)) begin
            h_eff = CMP_W'(rilbp_pkg::MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    assign col_nx     = CMP_W'(r_col) + CMP_W'(1);
    assign row_nx     = CMP_W'(r_row) + CMP_W'(1);
    assign row_wrap   = col_nx >= w_eff;
    assign frame_wrap = row_nx >= h_eff;

    assign o_col              = r_col;
    assign o_meta.interior    = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign o_meta.row_end     = row_wrap;
    assign o_meta.frame_end   = row_wrap && frame_wrap;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (row_wrap) begin
                n_col = '0;
                n_row = frame_wrap ? '0 : row_nx[RW-1:0];
            end else begin
                n_col = col_nx[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rilbp_pkg::CFG_W'(rilbp_pkg::MIN_SIDE);
            r_height <= rilbp_pkg::CFG_W'(rilbp_pkg::MIN_SIDE);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we && (i_cfg_index == rilbp_pkg::REG_IMAGE_WIDTH ||
                                  i_cfg_index == rilbp_pkg::REG_IMAGE_HEIGHT)) begin
            // a write to either size register restarts the frame
            if (i_cfg_index == rilbp_pkg::REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/rilbp_linebuf.sv =====
module rilbp_linebuf #(
    parameter int MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [PIXEL_BITS-1:0]        i_pixel,
    input  rilbp_pkg::t_meta             i_meta,
    output logic                         o_valid,
    input  logic                         i_take,
    output logic [PIXEL_BITS-1:0]        o_upper,
    output logic [PIXEL_BITS-1:0]        o_middle,
    output logic [PIXEL_BITS-1:0]        o_pixel,
    output rilbp_pkg::t_meta             o_meta
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

    logic                  r_valid;
    logic [CW-1:0]         r_col;
    logic [PIXEL_BITS-1:0] r_upper, r_middle, r_pixel;
    rilbp_pkg::t_meta      r_meta;
    logic                  load, leave;

    assign leave   = r_valid && i_take;
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (leave) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_upper  <= upper_mem[i_col];
            r_middle <= middle_mem[i_col];
            r_col    <= i_col;
            r_pixel  <= i_pixel;
            r_meta   <= i_meta;
        end
    end

    // rows shift down a store as the request moves on; within a frame the same
    // column is read again no sooner than a full row later
    always_ff @(posedge i_clk) begin
        if (leave) begin
            upper_mem[r_col]  <= r_middle;
            middle_mem[r_col] <= r_pixel;
        end
    end

    assign o_valid  = r_valid;
    assign o_upper  = r_upper;
    assign o_middle = r_middle;
    assign o_pixel  = r_pixel;
    assign o_meta   = r_meta;

endmodule

// ===== rtl/rilbp_core.sv =====
module rilbp_core #(
    parameter int PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_take,
    input  logic [PIXEL_BITS-1:0]             i_upper,
    input  logic [PIXEL_BITS-1:0]             i_middle,
    input  logic [PIXEL_BITS-1:0]             i_pixel,
    input  rilbp_pkg::t_meta                  i_meta,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rilbp_pkg::CODE_W-1:0]      o_code,
    output logic                              o_row_end,
    output logic                              o_frame_end
);

    logic [PIXEL_BITS-1:0]          r_win [3][3];
    logic                           r_s2_valid, r_s2_row_end, r_s2_frame_end;
    logic                           r_out_valid, r_out_row_end, r_out_frame_end;
    logic [rilbp_pkg::CODE_W-1:0]   r_out_code;
    logic [rilbp_pkg::CODE_W-1:0]   cmp_byte;
    logic [PIXEL_BITS-1:0]          nb [8];
    logic                           s2_adv, s1_in;

    assign s2_adv = !r_out_valid || !i_stall;
    assign o_take = !r_s2_valid || s2_adv;
    assign s1_in  = i_valid && o_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_in) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_upper;
            r_win[1][2] <= i_middle;
            r_win[2][2] <= i_pixel;
        end
    end

    // clockwise from top-left, top-left in the MSB
    always_comb begin
        nb[0] = r_win[0][0];
        nb[1] = r_win[0][1];
        nb[2] = r_win[0][2];
        nb[3] = r_win[1][2];
        nb[4] = r_win[2][2];
        nb[5] = r_win[2][1];
        nb[6] = r_win[2][0];
        nb[7] = r_win[1][0];
        for (int i = 0; i < 8; i++) begin
            cmp_byte[7-i] = nb[i] >= r_win[1][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_in) begin
                r_s2_valid <= i_meta.interior;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_in) begin
            r_s2_row_end   <= i_meta.row_end;
            r_s2_frame_end <= i_meta.frame_end;
        end
        if (s2_adv && r_s2_valid) begin
            r_out_code      <= rilbp_pkg::min_rotation(cmp_byte);
            r_out_row_end   <= r_s2_row_end;
            r_out_frame_end <= r_s2_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code      = r_out_code;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// ===== rtl/rilbp_checker.sv =====
module rilbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_pattern_code,
    input logic       o_row_end,
    input logic       o_frame_end
);

    // a frame end is always also a row end
    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    // input backpressure only when the result side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pattern_code) && $stable(o_row_end) &&
             $stable(o_frame_end)))
        else $error("stalled result changed");

endmodule

bind rotation_invariant_lbp_3x3 rilbp_checker u_rilbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pattern_code (o_pattern_code),
    .o_row_end      (o_row_end),
    .o_frame_end    (o_frame_end)
);

// ===== dv/rotation_invariant_lbp_3x3_tb.sv =====
`timescale 1ns / 100ps

module rotation_invariant_lbp_3x3_tb;

    localparam int          MAX_W         = rilbp_pkg::MAX_WIDTH_DEF;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          TALL_ROWS     = 40;

    localparam int MODE_RANDOM = 0;
    localparam int MODE_NARROW = 1;
    localparam int MODE_BINARY = 2;

    typedef struct packed {
        logic [rilbp_pkg::CODE_W-1:0] code;
        logic                         row_end;
        logic                         frame_end;
    } t_lbp_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [7:0]                        i_pixel = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [rilbp_pkg::CODE_W-1:0]      o_pattern_code;
    logic                              o_row_end;
    logic                              o_frame_end;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [rilbp_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [rilbp_pkg::CFG_W-1:0]       i_cfg_data = '0;

    rotation_invariant_lbp_3x3 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pattern_code (o_pattern_code),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    bit [rilbp_pkg::CFG_W-1:0] cfg_w = rilbp_pkg::CFG_W'(rilbp_pkg::MIN_SIDE);
    bit [rilbp_pkg::CFG_W-1:0] cfg_h = rilbp_pkg::CFG_W'(rilbp_pkg::MIN_SIDE);
    bit [7:0]       upper_row [MAX_W];
    bit [7:0]       middle_row [MAX_W];
    bit [7:0]       win [3][3];
    int unsigned    col_pos = 0;
    int unsigned    row_pos = 0;

    t_lbp_result    expected_codes [$];
    bit [7:0]       pending_pixels [$];

    int             error_count = 0;
    int             in_count = 0;
    int             result_count = 0;
    int unsigned    cycle_count = 0;
    bit             steady = 1'b0;

    int             gap_left = 0;
    int             stall_left = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;

    function automatic int unsigned side_of(input bit [rilbp_pkg::CFG_W-1:0] v,
                                            input int unsigned hi);
        if (v < rilbp_pkg::MIN_SIDE) begin
            return rilbp_pkg::MIN_SIDE;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic lbp_predict(input bit [7:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int          i;
        int          k;
        bit [7:0]    c;
        bit [7:0]    pat;
        bit [7:0]    best;
        bit [7:0]    rot;
        bit [15:0]   dbl;
        t_lbp_result res;
        w   = side_of(cfg_w, MAX_W);
        h   = side_of(cfg_h, rilbp_pkg::MAX_HEIGHT);
        col = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]       = upper_row[col];
        win[1][2]       = middle_row[col];
        win[2][2]       = px;
        upper_row[col]  = middle_row[col];
        middle_row[col] = px;

        if (row_pos >= 2 && col_pos >= 2) begin
            c   = win[1][1];
            // clockwise from top-left, top-left in the msb
            pat = {win[0][0] >= c, win[0][1] >= c, win[0][2] >= c, win[1][2] >= c,
                   win[2][2] >= c, win[2][1] >= c, win[2][0] >= c, win[1][0] >= c};
            best = pat;
            dbl  = {pat, pat};
            for (k = 1; k < 8; k++) begin
                rot = dbl[15-k -: 8];
                if (rot < best) begin
                    best = rot;
                end
            end
            res.code      = best;
            res.row_end   = (col_pos + 1 >= w);
            res.frame_end = res.row_end && (row_pos + 1 >= h);
            expected_codes.push_back(res);
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endtask

    // input side: a request is taken when valid is high and stall is low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                lbp_predict(i_pixel);
                in_count <= in_count + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_pixel    <= pending_pixels.pop_front();
                    gap_left   <= steady ? 0 : idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall, with one long hold-off while the input still has work queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && in_count >= 20 && pending_pixels.size() >= 20) begin
            hold_left   <= 400;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left  <= idle_len();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_lbp_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_codes.size() == 0) begin
                if (error_count < 10) begin
                    $display("unexpected result: code %02h row_end %0b frame_end %0b",
                             o_pattern_code, o_row_end, o_frame_end);
                end
                error_count <= error_count + 1;
            end else begin
                want = expected_codes.pop_front();
                if (o_pattern_code !== want.code || o_row_end !== want.row_end ||
                    o_frame_end !== want.frame_end) begin
                    if (error_count < 10) begin
                        $display({"result %0d: expected code %02h row_end %0b ",
                                  "frame_end %0b, got %02h %0b %0b"},
                                 result_count, want.code, want.row_end,
                                 want.frame_end, o_pattern_code, o_row_end,
                                 o_frame_end);
                    end
                    error_count <= error_count + 1;
                end
            end
            result_count <= result_count + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rotation_invariant_lbp_3x3 test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [rilbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rilbp_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rilbp_pkg::REG_IMAGE_WIDTH || idx == rilbp_pkg::REG_IMAGE_HEIGHT) begin
            if (idx == rilbp_pkg::REG_IMAGE_WIDTH) begin
                cfg_w = data;
            end else begin
                cfg_h = data;
            end
            // a size write restarts the frame
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // idle: nothing queued, nothing in flight, then let border pixels drain
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || i_in_valid || expected_codes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic feed_pixels(input int count, input int mode);
        int n;
        @(negedge i_clk);
        steady = ($urandom_range(0, 4) == 0);
        for (n = 0; n < count; n++) begin
            case (mode)
                MODE_RANDOM: pending_pixels.push_back(8'($urandom_range(0, 255)));
                // narrow range, so ties with the centre are common
                MODE_NARROW: pending_pixels.push_back(8'($urandom_range(120, 123)));
                default: pending_pixels.push_back($urandom_range(0, 1) ? 8'hff : 8'h00);
            endcase
        end
        wait_idle();
    endtask

    initial begin
        int                               random_items;
        int                               action;
        int                               w;
        int                               h;
        int                               count;
        int                               r;
        logic [rilbp_pkg::CFG_IDX_W-1:0]  idx;
        random_items = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes 3x3: flat frame, single set neighbour, alternating neighbours
        @(negedge i_clk);
        repeat (9) pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'h00); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff); pending_pixels.push_back(8'hfe);
        pending_pixels.push_back(8'h00); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'd100); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff); pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hff);
        wait_idle();

        // narrowest row (width below range), tall frame (height above range),
        // stopping part way down
        write_reg(rilbp_pkg::REG_IMAGE_WIDTH, rilbp_pkg::CFG_W'(1));
        write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, '1);
        feed_pixels(rilbp_pkg::MIN_SIDE * TALL_ROWS, MODE_RANDOM);

        while (random_items < RANDOM_ITEMS) begin
            action = $urandom_range(0, 9);
            r = $urandom_range(0, 9);
            w = (r < 3) ? $urandom_range(0, 2) : (r < 8) ? $urandom_range(3, 12)
                                                        : $urandom_range(13, 40);
            h = $urandom_range(0, 7);
            if (action < 4) begin
                write_reg(rilbp_pkg::REG_IMAGE_WIDTH, rilbp_pkg::CFG_W'(w));
                write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, rilbp_pkg::CFG_W'(h));
            end else if (action < 6) begin
                write_reg(rilbp_pkg::REG_IMAGE_WIDTH, rilbp_pkg::CFG_W'(w));
            end else if (action < 7) begin
                write_reg(rilbp_pkg::REG_IMAGE_HEIGHT, rilbp_pkg::CFG_W'(h));
            end else if (action < 8) begin
                do begin
                    idx = rilbp_pkg::CFG_IDX_W'($urandom);
                end while (idx == rilbp_pkg::REG_IMAGE_WIDTH ||
                           idx == rilbp_pkg::REG_IMAGE_HEIGHT);
                write_reg(idx, rilbp_pkg::CFG_W'($urandom_range(0, 2047)));
            end
            w = side_of(cfg_w, MAX_W);
            h = side_of(cfg_h, rilbp_pkg::MAX_HEIGHT);
            count = w * h * $urandom_range(1, 2);
            // some phases stop part way into a frame
            if ($urandom_range(0, 2) == 0) begin
                count += $urandom_range(1, w * h - 1);
            end
            if (count > RANDOM_ITEMS - random_items) begin
                count = RANDOM_ITEMS - random_items;
            end
            feed_pixels(count, $urandom_range(MODE_RANDOM, MODE_BINARY));
            random_items += count;
        end

        if (error_count == 0) begin
            $display("rotation_invariant_lbp_3x3 test passed");
        end else begin
            $display("rotation_invariant_lbp_3x3 test failed");
        end
        $finish;
    end

endmodule
